// File: rtl/assert_macros.svh
// Assertion helpers for the clocked checks at the end of the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int CFG_W       = 5;
	localparam int PAGE_W      = 16;
	localparam int OUT_IDX_W   = 4;
	localparam int FAULT_W     = 32;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              last_request;
	} in_t;

	typedef struct packed {
		logic                 hit;
		logic [OUT_IDX_W-1:0] frame_index;
		logic [FAULT_W-1:0]   fault_count;
		logic                 final_res;
	} out_t;

endpackage

// File: rtl/lru_page_replacement.sv
// LRU page replacement unit.
// in channel: in_valid / in_stall / in_data, one page request per beat.
// out channel: out_valid / out_stall / out_data, one result beat per request
// (hit flag, frame used, running fault count, end-of-sequence echo).
// cfg_we / cfg_wdata write frames_in_use; write it only while the block is idle.
// Each frame lives in one cell of a row of MAX_FRAMES cells. A request walks
// the row through the registered scan carry, one cell per cycle, collecting
// the first matching frame, the first empty frame and the LRU victim. An
// update step then broadcasts the decision and the cells update their ranks.
// A new request is taken only once the current one has finished its update,
// as in_stall is held outside the idle state.
// A result waiting in the output register does not block the next request;
// only the update cycle waits while out_stall holds an older result.
// Reset clears all frames, ranks and the fault counter, and sets
// frames_in_use to 16. A request marked last clears the frames, ranks and
// the fault counter after its result is formed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_page_replacement #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  lpr_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lpr_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [lpr_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int SW = 2 + 5 * IW;
	localparam int UW = 4 + 2 * IW;

	typedef struct packed {
		logic          hit_found;
		logic [IW-1:0] hit_idx;
		logic [IW-1:0] hit_rank;
		logic          empty_found;
		logic [IW-1:0] empty_idx;
		logic [IW-1:0] vic_idx;
		logic [IW-1:0] vic_rank;
	} scan_t;

	typedef struct packed {
		logic          go;
		logic          age_all;
		logic          wr_page;
		logic          clear;
		logic [IW-1:0] sel;
		logic [IW-1:0] bound;
	} upd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                         state_q;
	logic [IW-1:0]                  cnt_q;
	logic [lpr_pkg::CFG_W-1:0]      frames_q;
	logic [PAGE_BITS-1:0]           page_q;
	logic                           last_q;
	logic [lpr_pkg::FAULT_W-1:0]    fault_q;
	logic [lpr_pkg::FAULT_W-1:0]    fault_d;
	logic                           out_valid_q;
	lpr_pkg::out_t                  out_q;
	logic [SW-1:0]                  chain [MAX_FRAMES+1];
	logic [MAX_FRAMES-1:0]          valid_vec;
	scan_t                          fin;
	upd_t                           upd;
	logic                           in_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign chain[0] = '0;
	assign fin      = scan_t'(chain[MAX_FRAMES]);

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		lpr_cell #(
			.IDX       (i),
			.IW        (IW),
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.frames_in_use (frames_q),
			.page          (page_q),
			.upd           (UW'(upd)),
			.scan_in       (chain[i]),
			.scan_out      (chain[i+1]),
			.valid         (valid_vec[i])
		);
	end

	always_comb begin
		upd       = '0;
		upd.go    = (state_q == ST_UPD) && (!out_valid_q || !out_stall);
		upd.clear = last_q;
		if (fin.hit_found) begin
			upd.sel   = fin.hit_idx;
			upd.bound = fin.hit_rank;
		end else if (fin.empty_found) begin
			upd.sel     = fin.empty_idx;
			upd.age_all = 1'b1;
			upd.wr_page = 1'b1;
		end else begin
			upd.sel     = fin.vic_idx;
			upd.bound   = fin.vic_rank;
			upd.wr_page = 1'b1;
		end
	end

	always_comb begin
		fault_d = fault_q;
		if (!fin.hit_found && (fault_q != '1)) begin
			fault_d = fault_q + lpr_pkg::FAULT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lpr_pkg::FRAMES_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd.go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == IW'(MAX_FRAMES - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd.go) begin
						state_q <= ST_IDLE;
						fault_q <= last_q ? '0 : fault_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			page_q <= PAGE_BITS'(in_data.page);
			last_q <= in_data.last_request;
		end
		if (upd.go) begin
			out_q.hit         <= fin.hit_found;
			out_q.frame_index <= lpr_pkg::OUT_IDX_W'(upd.sel);
			out_q.fault_count <= fault_d;
			out_q.final_res   <= last_q;
		end
	end

	`ASSERT_CLK(a_out_from_upd, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_UPD), "result appeared without an update cycle")
	`ASSERT_CLK(a_frame0_filled, clk, arst_n, (upd.go && !last_q) |=> valid_vec[0], "frame 0 empty after a request")
	`ASSERT_CLK(a_fault_mono, clk, arst_n, (upd.go && !last_q) |=> (fault_q >= $past(fault_q)), "fault count went down mid-sequence")
	`ASSERT_CLK_ALWAYS(a_reset_idle, clk, !arst_n |=> (state_q == ST_IDLE) && !out_valid_q, "block not idle in reset")

endmodule

// File: rtl/lpr_cell.sv
`timescale 1ns / 1ps

module lpr_cell #(
	parameter int IDX       = 0,
	parameter int IW        = 4,
	parameter int PAGE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lpr_pkg::CFG_W-1:0] frames_in_use,
	input  logic [PAGE_BITS-1:0]      page,
	input  logic [4+2*IW-1:0]         upd,
	input  logic [2+5*IW-1:0]         scan_in,
	output logic [2+5*IW-1:0]         scan_out,
	output logic                      valid
);

	typedef struct packed {
		logic          hit_found;
		logic [IW-1:0] hit_idx;
		logic [IW-1:0] hit_rank;
		logic          empty_found;
		logic [IW-1:0] empty_idx;
		logic [IW-1:0] vic_idx;
		logic [IW-1:0] vic_rank;
	} scan_t;

	typedef struct packed {
		logic          go;
		logic          age_all;
		logic          wr_page;
		logic          clear;
		logic [IW-1:0] sel;
		logic [IW-1:0] bound;
	} upd_t;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic                 valid_q;
	logic [IW-1:0]        rank_q;
	logic [PAGE_BITS-1:0] page_q;
	scan_t                scan_i;
	scan_t                scan_d;
	scan_t                scan_q;
	upd_t                 upd_i;
	logic                 act;
	logic                 sel_me;

	assign scan_i   = scan_t'(scan_in);
	assign upd_i    = upd_t'(upd);
	assign act      = (IDX == 0) || (IDX < int'(frames_in_use));
	assign sel_me   = (upd_i.sel == MY_IDX);
	assign scan_out = scan_q;
	assign valid    = valid_q;

	always_comb begin
		scan_d = scan_i;
		if (act && valid_q && (page_q == page) && !scan_i.hit_found) begin
			scan_d.hit_found = 1'b1;
			scan_d.hit_idx   = MY_IDX;
			scan_d.hit_rank  = rank_q;
		end
		if (act && !valid_q && !scan_i.empty_found) begin
			scan_d.empty_found = 1'b1;
			scan_d.empty_idx   = MY_IDX;
		end
		if (act && (rank_q >= scan_i.vic_rank)) begin
			scan_d.vic_idx  = MY_IDX;
			scan_d.vic_rank = rank_q;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		if (upd_i.go && sel_me && upd_i.wr_page) begin
			page_q <= page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd_i.go) begin
			if (upd_i.clear) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (sel_me) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (upd_i.age_all || (rank_q < upd_i.bound))) begin
				rank_q <= rank_q + IW'(1);
			end
		end
	end

endmodule
